@@ hdl/slc_pkg.sv @@
// Shared types, codes and constants of the segment LCD compositor.
package slc_pkg;

  localparam int unsigned MaxSegmentsDef = 128;
  localparam int unsigned CovDepthDef    = 65536;
  localparam int unsigned CntW           = 9;
  localparam int unsigned WalkIdxW       = 8;
  localparam logic [7:0]  CovOpaque      = 8'hff;

  typedef enum logic [1:0] {
    OP_WR_DESC  = 2'd0,
    OP_WR_COV   = 2'd1,
    OP_SET_LIT  = 2'd2,
    OP_SHADE    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_PIXEL = 2'd1,
    KIND_DIRTY = 2'd2,
    KIND_NONE  = 2'd3
  } kind_e;

  typedef struct packed {
    logic [15:0] bg_color;
    logic        lit_value;
    logic [7:0]  cov_value;
    logic [15:0] cov_addr;
    logic [9:0]  size_h;
    logic [9:0]  size_w;
    logic [9:0]  pos_y;
    logic [9:0]  pos_x;
    logic [6:0]  seg_index;
  } in_beat_t;

  typedef struct packed {
    logic [15:0] cov_base;
    logic [9:0]  height;
    logic [9:0]  width;
    logic [9:0]  top;
    logic [9:0]  left;
  } seg_desc_t;

  typedef struct packed {
    logic                accept;
    logic                walk_rd;
    logic [WalkIdxW-1:0] walk_idx;
    logic                load_out;
  } cmd_t;

  typedef struct packed {
    logic pipe_empty;
    logic out_free;
  } status_t;

  function automatic logic [15:0] darken565(input logic [15:0] bg, input logic [7:0] c);
    logic [12:0] r;
    logic [13:0] g;
    logic [12:0] b;
    r = bg[15:11] * c;
    g = bg[10:5] * c;
    b = bg[4:0] * c;
    return {r[12:8], g[13:8], b[12:8]};
  endfunction

endpackage

@@ hdl/segment_lcd_compositor.sv @@
// Top level of the segment LCD compositor.
// Descriptor write, coverage write and lit update: no walk; the result is loaded once the output is free.
// Shade: the controller walks N = min(segments_in_use, MAX_SEGMENTS) segment table entries,
// one segment table entry per cycle, then waits for the shade pipeline to drain; with N = 0 there is no walk.
// One item in flight: a new beat is taken only after the last result is loaded, later while the output stalls.
// Reset clears lit bits, segments_in_use and control; table and coverage memories are not cleared.
module segment_lcd_compositor #(
  parameter int unsigned MAX_SEGMENTS = slc_pkg::MaxSegmentsDef,
  parameter int unsigned COV_DEPTH    = slc_pkg::CovDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // seg_index, pos_x, pos_y, size_w, size_h, cov_addr, cov_value, lit_value, bg_color
  input  logic [87:0] s_axis_tdata,
  // opcode
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // out_color, dirty_x, dirty_y, dirty_w, dirty_h
  output logic [55:0] m_axis_tdata,
  // result_kind
  output logic [1:0]  m_axis_tuser,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i
);

  slc_pkg::cmd_t    cmd;
  slc_pkg::status_t status;

  assign cfg_ready_o = 1'b1;

  slc_ctrl #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_op_i    (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .cfg_we_i   (cfg_valid_i),
    .cfg_data_i (cfg_data_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  slc_datapath #(.MAX_SEGMENTS(MAX_SEGMENTS), .COV_DEPTH(COV_DEPTH)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_op_i     (s_axis_tuser),
    .in_beat_i   (slc_pkg::in_beat_t'(s_axis_tdata)),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_kind_o  (m_axis_tuser),
    .out_data_o  (m_axis_tdata)
  );

endmodule

@@ hdl/slc_ctrl.sv @@
// Controller state machine: item sequencing and segment walk counter.
module slc_ctrl #(
  parameter int unsigned MAX_SEGMENTS = slc_pkg::MaxSegmentsDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [1:0]       in_op_i,
  output logic             in_ready_o,
  input  logic             cfg_we_i,
  input  logic [7:0]       cfg_data_i,
  input  slc_pkg::status_t status_i,
  output slc_pkg::cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_WALK   = 4'b0010,
    S_DRAIN  = 4'b0100,
    S_RESULT = 4'b1000
  } state_e;

  state_e                      state_q, state_d;
  logic [7:0]                  seg_use_q;
  logic [slc_pkg::CntW-1:0]    cnt_q, cnt_d;
  logic [slc_pkg::CntW-1:0]    limit;
  logic                        accept;

  assign limit = (slc_pkg::CntW'(seg_use_q) > slc_pkg::CntW'(MAX_SEGMENTS)) ?
                 slc_pkg::CntW'(MAX_SEGMENTS) : slc_pkg::CntW'(seg_use_q);
  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    cmd_o.accept   = accept;
    cmd_o.walk_idx = cnt_q[slc_pkg::WalkIdxW-1:0];
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cnt_d = '0;
          if (in_op_i == slc_pkg::OP_SHADE && limit != '0) begin
            state_d = S_WALK;
          end else begin
            state_d = S_RESULT;
          end
        end
      end
      S_WALK: begin
        cmd_o.walk_rd = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == limit - 1'b1) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (status_i.pipe_empty) begin
          state_d = S_RESULT;
        end
      end
      S_RESULT: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      seg_use_q <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (cfg_we_i) begin
        seg_use_q <= cfg_data_i;
      end
    end
  end

endmodule

@@ hdl/slc_datapath.sv @@
// Datapath: segment table, lit bits, coverage memory, shade pipeline, result register.
module slc_datapath #(
  parameter int unsigned MAX_SEGMENTS = slc_pkg::MaxSegmentsDef,
  parameter int unsigned COV_DEPTH    = slc_pkg::CovDepthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [1:0]         in_op_i,
  input  slc_pkg::in_beat_t  in_beat_i,
  input  slc_pkg::cmd_t      cmd_i,
  output slc_pkg::status_t   status_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         out_kind_o,
  output logic [55:0]        out_data_o
);

  localparam int unsigned IdxW  = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int unsigned CovAw = $clog2(COV_DEPTH);

  slc_pkg::seg_desc_t tbl_mem [MAX_SEGMENTS];
  logic [7:0]         cov_mem [COV_DEPTH];
  logic [MAX_SEGMENTS-1:0] lit_q;

  logic [1:0]  op_q;
  logic [9:0]  px_q, py_q;
  logic        lit_dirty_q;
  logic [15:0] color_q;

  slc_pkg::seg_desc_t tbl_rd_q;
  logic [IdxW-1:0]    tbl_addr;
  logic               tbl_rd;
  logic [IdxW-1:0]    in_idx;
  logic [IdxW-1:0]    walk_idx;
  logic               idx_ok;

  logic        v1_q, lit1_q;
  logic        v2_q, hit2_q;
  logic [19:0] prod2_q;
  logic [9:0]  dx2_q;
  logic [15:0] base2_q;
  logic        v3_q, hit3_q;
  logic [7:0]  cov_rd_q;
  logic        hit1;
  logic [21:0] cov_sum;

  logic        out_valid_q;
  logic [1:0]  out_kind_q;
  logic [55:0] out_data_q;

  assign in_idx   = IdxW'(in_beat_i.seg_index);
  assign walk_idx = cmd_i.walk_idx[IdxW-1:0];
  assign idx_ok   = 9'(in_beat_i.seg_index) < 9'(MAX_SEGMENTS);
  assign tbl_rd   = cmd_i.walk_rd || (cmd_i.accept && in_op_i == slc_pkg::OP_SET_LIT && idx_ok);
  assign tbl_addr = cmd_i.walk_rd ? walk_idx : in_idx;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && in_op_i == slc_pkg::OP_WR_DESC && idx_ok) begin
      tbl_mem[in_idx] <= '{cov_base: in_beat_i.cov_addr, height: in_beat_i.size_h,
                           width: in_beat_i.size_w, top: in_beat_i.pos_y,
                           left: in_beat_i.pos_x};
    end
    if (tbl_rd) begin
      tbl_rd_q <= tbl_mem[tbl_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lit_q <= '0;
    end else if (cmd_i.accept && in_op_i == slc_pkg::OP_SET_LIT && idx_ok) begin
      lit_q[in_idx] <= in_beat_i.lit_value;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q        <= in_op_i;
      px_q        <= in_beat_i.pos_x;
      py_q        <= in_beat_i.pos_y;
      lit_dirty_q <= idx_ok && (lit_q[in_idx] != in_beat_i.lit_value);
    end
    lit1_q <= lit_q[walk_idx];
  end

  assign hit1 = lit1_q && tbl_rd_q.width != '0 && tbl_rd_q.height != '0 &&
                px_q >= tbl_rd_q.left &&
                11'(px_q) < 11'(tbl_rd_q.left) + 11'(tbl_rd_q.width) &&
                py_q >= tbl_rd_q.top &&
                11'(py_q) < 11'(tbl_rd_q.top) + 11'(tbl_rd_q.height);

  always_ff @(posedge clk_i) begin
    prod2_q <= (py_q - tbl_rd_q.top) * tbl_rd_q.width;
    dx2_q   <= px_q - tbl_rd_q.left;
    base2_q <= tbl_rd_q.cov_base;
    hit2_q  <= hit1;
    hit3_q  <= hit2_q;
  end

  assign cov_sum = 22'(base2_q) + 22'(prod2_q) + 22'(dx2_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && in_op_i == slc_pkg::OP_WR_COV) begin
      cov_mem[CovAw'(in_beat_i.cov_addr)] <= in_beat_i.cov_value;
    end
    if (v2_q && hit2_q) begin
      cov_rd_q <= cov_mem[cov_sum[CovAw-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.walk_rd;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      color_q <= in_beat_i.bg_color;
    end else if (v3_q && hit3_q && cov_rd_q != slc_pkg::CovOpaque) begin
      color_q <= slc_pkg::darken565(color_q, cov_rd_q);
    end
  end

  assign status_o.pipe_empty = !v1_q && !v2_q && !v3_q;
  assign status_o.out_free   = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      case (op_q)
        slc_pkg::OP_WR_DESC, slc_pkg::OP_WR_COV: begin
          out_kind_q <= slc_pkg::KIND_WRITE;
          out_data_q <= '0;
        end
        slc_pkg::OP_SET_LIT: begin
          if (lit_dirty_q && tbl_rd_q.width != '0 && tbl_rd_q.height != '0) begin
            out_kind_q <= slc_pkg::KIND_DIRTY;
            out_data_q <= {tbl_rd_q.height, tbl_rd_q.width, tbl_rd_q.top,
                           tbl_rd_q.left, 16'h0000};
          end else begin
            out_kind_q <= slc_pkg::KIND_NONE;
            out_data_q <= '0;
          end
        end
        default: begin
          out_kind_q <= slc_pkg::KIND_PIXEL;
          out_data_q <= {40'h0, color_q};
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_kind_o  = out_kind_q;
  assign out_data_o  = out_data_q;

endmodule

@@ hdl/slc_checker.sv @@
// Port-level checker of the segment LCD compositor and its bind.
module slc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [55:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("result beat changed while stalled");

  a_write_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == slc_pkg::KIND_WRITE || m_axis_tuser == slc_pkg::KIND_NONE)
      |-> m_axis_tdata == '0)
    else $error("write or no-repaint beat carries data");

  a_dirty_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == slc_pkg::KIND_DIRTY
      |-> m_axis_tdata[45:36] != '0 && m_axis_tdata[55:46] != '0 && m_axis_tdata[15:0] == '0)
    else $error("dirty rectangle empty or color set");

  a_pixel_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == slc_pkg::KIND_PIXEL |-> m_axis_tdata[55:16] == '0)
    else $error("pixel beat carries rectangle");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input beat taken while an item is in flight");

endmodule

bind segment_lcd_compositor slc_checker u_slc_checker (.*);
